[src/ppsa_pkg.sv]
// Shared types and constants for the priority port share arbiter.
// No dependencies; imported by the slot store and the top level.
package ppsa_pkg;

    localparam int SLOTS         = 16;
    localparam int SETTINGS_BITS = 32;
    localparam int IDX_W         = $clog2(SLOTS);
    localparam int CNT_W         = $clog2(SLOTS + 1);
    localparam int ID_W          = 22;
    localparam int SLOT_W        = 4;
    localparam int CFG_W         = 32;
    localparam int HC_W          = 5;

    typedef enum logic [1:0] {
        ACT_OPEN       = 2'd0,
        ACT_CLOSE      = 2'd1,
        ACT_CHANGE     = 2'd2,
        ACT_DISCONNECT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_UNKNOWN_ID = 2'd2,
        ST_INACTIVE   = 2'd3
    } status_t;

    // Write request into the per-slot owner and saved-settings memories.
    typedef struct packed {
        logic                     owner_we;
        logic                     saved_we;
        logic [IDX_W-1:0]         waddr;
        logic [ID_W-1:0]          owner_data;
        logic [SETTINGS_BITS-1:0] saved_data;
    } store_wr_t;

endpackage

[src/ppsa_slot_store.sv]
// Per-slot owner id and saved settings memories, one write and one
// registered read each. Depends on ppsa_pkg.
module ppsa_slot_store
    import ppsa_pkg::*;
(
    input  logic                     clk,
    input  store_wr_t                wr,
    input  logic [IDX_W-1:0]         owner_raddr,
    input  logic [IDX_W-1:0]         saved_raddr,
    output logic [ID_W-1:0]          owner_q,
    output logic [SETTINGS_BITS-1:0] saved_q
);

    logic [ID_W-1:0]          owner_mem [SLOTS];
    logic [SETTINGS_BITS-1:0] saved_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.owner_we)
        begin
            owner_mem[wr.waddr] <= wr.owner_data;
        end
        owner_q <= owner_mem[owner_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.saved_we)
        begin
            saved_mem[wr.waddr] <= wr.saved_data;
        end
        saved_q <= saved_mem[saved_raddr];
    end

endmodule

[src/priority_port_share_arbiter_core.sv]
// Top level of the priority port share arbiter: sequencer, slot flags and
// result registers. Depends on ppsa_pkg and ppsa_slot_store.
//
//  channel   | signals                                       | handshake
//  ----------+-----------------------------------------------+----------------------
//  command   | action high_priority client_id slot_index     | start & !busy
//            | req_settings                                  |
//  result    | status slot_used port_written port_settings   | done, one cycle
//            | client_paused high_count                      |
//  config    | cfg_data (boot settings word)                 | cfg_valid & cfg_ready
//
// One item is worked at a time by a slot scan counter that steps one slot per
// cycle. Close by id and a disconnect of the last high client cost the most;
// the owner memory read port sets the id search pace.
// Reset clears slot flags, the high count and the port settings (to zero);
// the owner and saved memories are not cleared.
// The receiver cannot stall: done pulses for one cycle and busy drops with it,
// so the next item may be accepted while a result is on the ports.
module priority_port_share_arbiter_core
    import ppsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic                 high_priority,
    input  logic [ID_W-1:0]      client_id,
    input  logic [SLOT_W-1:0]    slot_index,
    input  logic [CFG_W-1:0]     req_settings,
    // result
    output logic                 done,
    output logic [1:0]           status,
    output logic [SLOT_W-1:0]    slot_used,
    output logic                 port_written,
    output logic [CFG_W-1:0]     port_settings,
    output logic                 client_paused,
    output logic [HC_W-1:0]      high_count,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND_FREE,
        S_FIND_ID,
        S_SWEEP,
        S_LAST_LOW,
        S_RESTORE_RD,
        S_RESTORE,
        S_REPORT
    } state_t;

    // sequencer and latched item
    state_t                   state_reg,       state_next;
    logic [CNT_W-1:0]         cnt_reg,         cnt_next;
    logic [1:0]               act_reg,         act_next;
    logic                     hi_reg,          hi_next;
    logic [ID_W-1:0]          id_reg,          id_next;
    logic [SLOT_W-1:0]        sidx_reg,        sidx_next;
    logic [SETTINGS_BITS-1:0] nset_reg,        nset_next;
    logic [SLOT_W-1:0]        slot_reg,        slot_next;
    status_t                  wstat_reg,       wstat_next;
    logic                     written_reg,     written_next;
    logic [IDX_W-1:0]         last_reg,        last_next;
    logic                     last_found_reg,  last_found_next;
    logic                     probe_vld_reg,   probe_vld_next;
    logic [IDX_W-1:0]         probe_idx_reg,   probe_idx_next;
    // slot flags and shared state
    logic [SLOTS-1:0]         active_reg,      active_next;
    logic [SLOTS-1:0]         paused_reg,      paused_next;
    logic [SLOTS-1:0]         is_high_reg,     is_high_next;
    logic [CNT_W-1:0]         ahigh_reg,       ahigh_next;
    logic [SETTINGS_BITS-1:0] applied_reg,     applied_next;
    // result registers
    logic                     done_reg,        done_next;
    status_t                  ostat_reg,       ostat_next;
    logic [SLOT_W-1:0]        oslot_reg,       oslot_next;
    logic                     owritten_reg,    owritten_next;
    logic [CFG_W-1:0]         oset_reg,        oset_next;
    logic                     opaused_reg,     opaused_next;
    logic [HC_W-1:0]          ohc_reg,         ohc_next;

    // memory side
    store_wr_t                store_wr;
    logic [ID_W-1:0]          owner_q;
    logic [SETTINGS_BITS-1:0] saved_q;

    // helpers
    logic [IDX_W-1:0]         cidx;
    logic                     cnt_live;
    logic [IDX_W-1:0]         tgt;
    logic                     sidx_ok;
    logic                     id_match;
    logic                     drop_go;
    logic [IDX_W-1:0]         drop_idx;
    logic [CNT_W-1:0]         ahigh_dec;
    logic [SLOTS-1:0]         low_mask;

    assign cidx     = cnt_reg[IDX_W-1:0];
    assign cnt_live = (cnt_reg < CNT_W'(SLOTS));
    assign tgt      = IDX_W'(slot_reg);
    assign sidx_ok  = (32'(sidx_reg) < SLOTS);
    assign id_match = probe_vld_reg && active_reg[probe_idx_reg] && (owner_q == id_reg);
    assign low_mask = active_reg & ~is_high_reg;

    ppsa_slot_store u_store (
        .clk         (clk),
        .wr          (store_wr),
        .owner_raddr (cidx),
        .saved_raddr (last_reg),
        .owner_q     (owner_q),
        .saved_q     (saved_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        act_next        = act_reg;
        hi_next         = hi_reg;
        id_next         = id_reg;
        sidx_next       = sidx_reg;
        nset_next       = nset_reg;
        slot_next       = slot_reg;
        wstat_next      = wstat_reg;
        written_next    = written_reg;
        last_next       = last_reg;
        last_found_next = last_found_reg;
        probe_vld_next  = 1'b0;
        probe_idx_next  = cidx;
        active_next     = active_reg;
        paused_next     = paused_reg;
        is_high_next    = is_high_reg;
        ahigh_next      = ahigh_reg;
        applied_next    = applied_reg;
        done_next       = 1'b0;
        ostat_next      = ostat_reg;
        oslot_next      = oslot_reg;
        owritten_next   = owritten_reg;
        oset_next       = oset_reg;
        opaused_next    = opaused_reg;
        ohc_next        = ohc_reg;
        store_wr        = '0;
        drop_go         = 1'b0;
        drop_idx        = tgt;
        ahigh_dec       = '0;

        case (state_reg)
            S_IDLE:
            begin
                // boot settings load straight into the applied word
                if (cfg_valid)
                begin
                    applied_next = SETTINGS_BITS'(cfg_data);
                end
                if (start)
                begin
                    act_next     = action;
                    hi_next      = high_priority;
                    id_next      = client_id;
                    sidx_next    = slot_index;
                    nset_next    = SETTINGS_BITS'(req_settings);
                    slot_next    = '0;
                    wstat_next   = ST_DONE;
                    written_next = 1'b0;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cnt_next = '0;
                case (action_t'(act_reg))
                    ACT_OPEN:
                    begin
                        state_next = S_FIND_FREE;
                    end
                    ACT_CLOSE:
                    begin
                        state_next = S_FIND_ID;
                    end
                    default:
                    begin
                        slot_next = sidx_reg;
                        if (!sidx_ok || !active_reg[IDX_W'(sidx_reg)])
                        begin
                            wstat_next = ST_INACTIVE;
                            state_next = S_REPORT;
                        end
                        else if (action_t'(act_reg) == ACT_DISCONNECT)
                        begin
                            drop_go  = 1'b1;
                            drop_idx = IDX_W'(sidx_reg);
                        end
                        else if (is_high_reg[IDX_W'(sidx_reg)])
                        begin
                            // high client: apply now, then copy into low clients
                            applied_next = nset_reg;
                            written_next = 1'b1;
                            state_next   = S_SWEEP;
                        end
                        else
                        begin
                            store_wr.saved_we   = 1'b1;
                            store_wr.waddr      = IDX_W'(sidx_reg);
                            store_wr.saved_data = nset_reg;
                            if (!paused_reg[IDX_W'(sidx_reg)])
                            begin
                                applied_next = nset_reg;
                                written_next = 1'b1;
                            end
                            state_next = S_REPORT;
                        end
                    end
                endcase
            end

            S_FIND_FREE:
            begin
                if (!cnt_live)
                begin
                    wstat_next = ST_FULL;
                    slot_next  = '0;
                    state_next = S_REPORT;
                end
                else if (!active_reg[cidx])
                begin
                    slot_next            = SLOT_W'(cidx);
                    active_next[cidx]    = 1'b1;
                    is_high_next[cidx]   = hi_reg;
                    store_wr.owner_we    = 1'b1;
                    store_wr.saved_we    = 1'b1;
                    store_wr.waddr       = cidx;
                    store_wr.owner_data  = id_reg;
                    store_wr.saved_data  = applied_reg;
                    if (hi_reg)
                    begin
                        ahigh_next        = ahigh_reg + 1'b1;
                        paused_next       = paused_reg | low_mask;
                        paused_next[cidx] = 1'b0;
                    end
                    else
                    begin
                        paused_next[cidx] = (ahigh_reg != '0);
                    end
                    state_next = S_REPORT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_FIND_ID:
            begin
                // read one owner per cycle, compare it the cycle after
                if (id_match)
                begin
                    slot_next = SLOT_W'(probe_idx_reg);
                    drop_go   = 1'b1;
                    drop_idx  = probe_idx_reg;
                end
                else if (!cnt_live && !probe_vld_reg)
                begin
                    wstat_next = ST_UNKNOWN_ID;
                    slot_next  = '0;
                    state_next = S_REPORT;
                end
                else if (cnt_live)
                begin
                    probe_vld_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end

            S_SWEEP:
            begin
                if (cnt_live)
                begin
                    if (low_mask[cidx])
                    begin
                        store_wr.saved_we   = 1'b1;
                        store_wr.waddr      = cidx;
                        store_wr.saved_data = nset_reg;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_LAST_LOW:
            begin
                if (cnt_live)
                begin
                    if (low_mask[cidx])
                    begin
                        last_next       = cidx;
                        last_found_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    // all low clients resume
                    paused_next = paused_reg & ~low_mask;
                    state_next  = last_found_reg ? S_RESTORE_RD : S_REPORT;
                end
            end

            S_RESTORE_RD:
            begin
                state_next = S_RESTORE;
            end

            S_RESTORE:
            begin
                applied_next = saved_q;
                written_next = 1'b1;
                state_next   = S_REPORT;
            end

            S_REPORT:
            begin
                done_next     = 1'b1;
                ostat_next    = wstat_reg;
                oslot_next    = slot_reg;
                owritten_next = written_reg;
                oset_next     = CFG_W'(applied_reg);
                opaused_next  = (wstat_reg == ST_DONE) && paused_reg[tgt];
                ohc_next      = HC_W'(ahigh_reg);
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // drop a client; the last high one leaving starts the restore scan
        if (drop_go)
        begin
            active_next[drop_idx] = 1'b0;
            paused_next[drop_idx] = 1'b0;
            state_next            = S_REPORT;
            if (is_high_reg[drop_idx])
            begin
                ahigh_dec  = (ahigh_reg != '0) ? (ahigh_reg - 1'b1) : '0;
                ahigh_next = ahigh_dec;
                if (ahigh_dec == '0)
                begin
                    cnt_next        = '0;
                    last_found_next = 1'b0;
                    state_next      = S_LAST_LOW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            act_reg        <= '0;
            hi_reg         <= 1'b0;
            id_reg         <= '0;
            sidx_reg       <= '0;
            nset_reg       <= '0;
            slot_reg       <= '0;
            wstat_reg      <= ST_DONE;
            written_reg    <= 1'b0;
            last_reg       <= '0;
            last_found_reg <= 1'b0;
            probe_vld_reg  <= 1'b0;
            probe_idx_reg  <= '0;
            active_reg     <= '0;
            paused_reg     <= '0;
            is_high_reg    <= '0;
            ahigh_reg      <= '0;
            applied_reg    <= '0;
            done_reg       <= 1'b0;
            ostat_reg      <= ST_DONE;
            oslot_reg      <= '0;
            owritten_reg   <= 1'b0;
            oset_reg       <= '0;
            opaused_reg    <= 1'b0;
            ohc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            act_reg        <= act_next;
            hi_reg         <= hi_next;
            id_reg         <= id_next;
            sidx_reg       <= sidx_next;
            nset_reg       <= nset_next;
            slot_reg       <= slot_next;
            wstat_reg      <= wstat_next;
            written_reg    <= written_next;
            last_reg       <= last_next;
            last_found_reg <= last_found_next;
            probe_vld_reg  <= probe_vld_next;
            probe_idx_reg  <= probe_idx_next;
            active_reg     <= active_next;
            paused_reg     <= paused_next;
            is_high_reg    <= is_high_next;
            ahigh_reg      <= ahigh_next;
            applied_reg    <= applied_next;
            done_reg       <= done_next;
            ostat_reg      <= ostat_next;
            oslot_reg      <= oslot_next;
            owritten_reg   <= owritten_next;
            oset_reg       <= oset_next;
            opaused_reg    <= opaused_next;
            ohc_reg        <= ohc_next;
        end
    end

    // Hold config off while an item is in flight.
    assign cfg_ready     = (state_reg == S_IDLE);
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = ostat_reg;
    assign slot_used     = oslot_reg;
    assign port_written  = owritten_reg;
    assign port_settings = oset_reg;
    assign client_paused = opaused_reg;
    assign high_count    = ohc_reg;

    // A result only ever comes out of the report step.
    a_done_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_REPORT))
        else $error("done without a report step");

    // Only active slots may be paused.
    a_paused_active: assert property (@(posedge clk) disable iff (!rst_n)
        (paused_reg & ~active_reg) == '0)
        else $error("inactive slot marked paused");

    // The high count never exceeds the number of active slots.
    a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ahigh_reg) <= $countones(active_reg))
        else $error("high count exceeds active slots");

    // An accepted item keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

endmodule
